// ===== rtl/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// DSC symbol decoder package
// Shared types, register indexes, constants and the symbol check function.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam logic [1:0] REG_INVERT        = 2'd0;
    localparam logic [1:0] REG_ERROR_LIMIT   = 2'd1;
    localparam logic [1:0] REG_PHASING       = 2'd2;

    localparam logic [3:0] BITS_PER_SYMBOL   = 4'd10;
    localparam logic [7:0] ERROR_COUNT_MAX   = 8'hFF;
    localparam logic [9:0] EMPTY_VALUE       = 10'h080;

    localparam logic [7:0] ERROR_LIMIT_RESET = 8'd4;
    localparam logic [6:0] PHASING_RESET     = 7'd125;

    typedef logic [9:0] t_code;

    typedef struct packed {
        logic       invert;
        logic [7:0] error_limit;
        logic [6:0] phasing_symbol;
    } t_cfg;

    // A symbol is valid when its top three bits count the zeros in its low seven.
    function automatic logic sym_valid(input t_code v);
        logic [2:0] zeros;
        zeros = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (!v[i]) begin
                zeros = zeros + 3'd1;
            end
        end
        return (v[9:7] == zeros);
    endfunction

endpackage

// ===== rtl/dsc_front.sv =====
// ----------------------------------------------------------------------------
// DSC front end
// Slices samples to bits, frames ten-bit symbols and tracks bit sync.
// ----------------------------------------------------------------------------
module dsc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dsc_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    input  logic signed [15:0] i_sample,
    input  logic               i_queue_full,
    output logic               o_push,
    output dsc_pkg::t_code     o_code
);

    logic           r_accept_unused;
    logic [9:0]     r_window;
    logic [3:0]     r_bits_needed;
    logic [7:0]     r_error_count;
    logic [9:0]     n_window;
    logic [3:0]     n_bits_needed;
    logic [7:0]     n_error_count;
    logic           w_accept;
    logic           w_positive;
    logic           w_bit;
    logic           w_ok;
    logic           w_push;
    dsc_pkg::t_code w_code;

    assign w_accept   = i_in_valid && !i_queue_full;
    assign w_positive = !i_sample[15] && (i_sample != 16'sd0);
    assign w_bit      = (w_positive == i_cfg.invert);

    always_comb begin
        n_window      = {w_bit, r_window[9:1]};
        n_bits_needed = r_bits_needed;
        n_error_count = r_error_count;
        w_push        = 1'b0;
        // Bits 7 and 9 of the received window trade places.
        w_code        = {n_window[7], n_window[8], n_window[9], n_window[6:0]};
        w_ok          = dsc_pkg::sym_valid(w_code);
        if (r_bits_needed > 4'd1) begin
            n_bits_needed = r_bits_needed - 4'd1;
        end else if (!w_ok && (r_error_count > i_cfg.error_limit)) begin
            // Out of sync: slide the window by one bit.
            n_bits_needed = 4'd1;
        end else begin
            n_bits_needed = dsc_pkg::BITS_PER_SYMBOL;
            w_push        = 1'b1;
            if (w_ok) begin
                n_error_count = 8'd0;
            end else if (r_error_count != dsc_pkg::ERROR_COUNT_MAX) begin
                n_error_count = r_error_count + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window        <= 10'd0;
            r_bits_needed   <= dsc_pkg::BITS_PER_SYMBOL;
            r_error_count   <= 8'd0;
            r_accept_unused <= 1'b0;
        end else begin
            r_accept_unused <= w_accept;
            if (w_accept) begin
                r_window      <= n_window;
                r_bits_needed <= n_bits_needed;
                r_error_count <= n_error_count;
            end
        end
    end

    assign o_push = w_accept && w_push;
    assign o_code = w_code;

    // The front end never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_queue_full) else $error("push into full queue");

    // A slide leaves the error count unchanged.
    a_slide_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_accept_unused && (r_bits_needed == 4'd1) && $past(r_bits_needed) <= 4'd1)
        |-> (r_error_count == $past(r_error_count)) || $past(o_push))
        else $error("error count changed on a slide");

endmodule

// ===== rtl/dsc_queue.sv =====
// ----------------------------------------------------------------------------
// DSC symbol queue
// Short FIFO of framed symbols between the front end and the back end.
// ----------------------------------------------------------------------------
module dsc_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsc_pkg::t_code i_code,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output dsc_pkg::t_code o_code
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dsc_pkg::t_code   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_code  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("pop from empty queue");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_rd_ptr == r_wr_ptr)) else $error("queue pointers disagree");

endmodule

// ===== rtl/dsc_back.sv =====
// ----------------------------------------------------------------------------
// DSC back end
// DX/RX phase tracking, DX delay line and time-diversity correction.
// ----------------------------------------------------------------------------
module dsc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dsc_pkg::t_cfg  i_cfg,
    input  logic           i_q_empty,
    input  dsc_pkg::t_code i_q_code,
    input  logic           i_out_stall,
    output logic           o_pop,
    output logic           o_out_valid,
    output logic [6:0]     o_symbol,
    output logic           o_empty_res
);

    logic           r_rx_phase;
    dsc_pkg::t_code r_dx [3];
    logic           r_out_valid;
    logic [6:0]     r_symbol;
    logic           r_empty_res;
    logic           w_rx;
    logic           w_res_ok;
    dsc_pkg::t_code w_d;
    dsc_pkg::t_code w_r;
    dsc_pkg::t_code w_res;

    assign o_pop = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign w_d   = r_dx[0];
    assign w_r   = i_q_code;
    // A phasing symbol always starts a DX slot.
    assign w_rx  = r_rx_phase && (w_r[6:0] != i_cfg.phasing_symbol);

    always_comb begin
        if (!w_rx) begin
            w_res = 10'd0;
        end else if (w_d[6:0] == i_cfg.phasing_symbol) begin
            w_res = w_r;
        end else if (w_d == w_r) begin
            w_res = w_r;
        end else if (dsc_pkg::sym_valid(w_r)) begin
            w_res = w_r;
        end else if (dsc_pkg::sym_valid(w_d)) begin
            w_res = w_d;
        end else if (dsc_pkg::sym_valid(w_d | w_r)) begin
            w_res = w_d | w_r;
        end else if (dsc_pkg::sym_valid(w_d & w_r)) begin
            w_res = w_d & w_r;
        end else begin
            w_res = dsc_pkg::EMPTY_VALUE;
        end
    end

    assign w_res_ok = dsc_pkg::sym_valid(w_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_phase  <= 1'b0;
            r_dx[0]     <= 10'd0;
            r_dx[1]     <= 10'd0;
            r_dx[2]     <= 10'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rx_phase  <= !w_rx;
                r_out_valid <= (w_res != 10'd0);
                if (!w_rx) begin
                    r_dx[0] <= r_dx[1];
                    r_dx[1] <= r_dx[2];
                    r_dx[2] <= w_r;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_symbol    <= w_res_ok ? w_res[6:0] : 7'd0;
            r_empty_res <= !w_res_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_empty_res = r_empty_res;

    // An empty word always carries a zero code.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty_res) |-> (r_symbol == 7'd0))
        else $error("empty word with nonzero code");

    // A DX slot never produces a word.
    a_dx_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !w_rx) |=> !r_out_valid) else $error("word from DX slot");

endmodule

// ===== rtl/dsc_symbol_sync_and_fec_top.sv =====
// ----------------------------------------------------------------------------
// DSC symbol sync and FEC top level
// Configuration registers and the front end, queue and back end chain.
// ----------------------------------------------------------------------------
// A result word is registered: the symbol whose RX slot ends with an accepted
// sample enters the queue when that sample is accepted, and the output register
// loads when the back end pops it. The block takes one sample per cycle; each
// stage handles one word per cycle while the output is not stalled, and input stalls only while the queue is full.
// Reset is synchronous and active low; it clears sync, phase, the DX delay
// line and the queue, and loads the register defaults.
module dsc_symbol_sync_and_fec_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    input  logic signed [15:0] i_sample,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output logic [6:0]         o_symbol,
    output logic               o_empty_res,
    input  logic               i_out_stall
);

    dsc_pkg::t_cfg  r_cfg;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    dsc_pkg::t_code w_front_code;
    dsc_pkg::t_code w_queue_code;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert         <= 1'b0;
            r_cfg.error_limit    <= dsc_pkg::ERROR_LIMIT_RESET;
            r_cfg.phasing_symbol <= dsc_pkg::PHASING_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                dsc_pkg::REG_INVERT:      r_cfg.invert         <= pwdata[0];
                dsc_pkg::REG_ERROR_LIMIT: r_cfg.error_limit    <= pwdata[7:0];
                dsc_pkg::REG_PHASING:     r_cfg.phasing_symbol <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dsc_pkg::REG_INVERT:      prdata = {31'd0, r_cfg.invert};
            dsc_pkg::REG_ERROR_LIMIT: prdata = {24'd0, r_cfg.error_limit};
            dsc_pkg::REG_PHASING:     prdata = {25'd0, r_cfg.phasing_symbol};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_in_stall = w_full;

    dsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .i_sample     (i_sample),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_code       (w_front_code)
    );

    dsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_code  (w_front_code),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_code  (w_queue_code)
    );

    dsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_empty),
        .i_q_code    (w_queue_code),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_symbol    (o_symbol),
        .o_empty_res (o_empty_res)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DSC symbol sync and FEC testbench
// Drives soft samples and register writes into the decoder, predicts every
// decoded word with a bit-exact model of the slicer, symbol framing and
// time-diversity stage, and compares each word as it leaves the block.
// ----------------------------------------------------------------------------

class dsc_decode_scoreboard;

    typedef struct packed {
        logic [6:0] symbol;
        logic       empty;
    } word_t;

    // Register copy
    logic              invert;
    logic [7:0]        error_limit;
    logic [6:0]        phasing_symbol;

    // Decoder state
    dsc_pkg::t_code    window;
    dsc_pkg::t_code    dx_line [3];
    logic [3:0]        bits_needed;
    logic [7:0]        err_count;
    logic              rx_phase;

    word_t             expected_words [$];
    int                errors;
    int                words_checked;
    int                empties;
    int                slides;

    function new();
        invert         = 1'b0;
        error_limit    = dsc_pkg::ERROR_LIMIT_RESET;
        phasing_symbol = dsc_pkg::PHASING_RESET;
        window         = '0;
        bits_needed    = dsc_pkg::BITS_PER_SYMBOL;
        err_count      = '0;
        rx_phase       = 1'b0;
        foreach (dx_line[i]) begin
            dx_line[i] = '0;
        end
        errors        = 0;
        words_checked = 0;
        empties       = 0;
        slides        = 0;
    endfunction

    static function logic code_ok(dsc_pkg::t_code v);
        int zeros;
        zeros = 0;
        for (int i = 0; i < 7; i++) begin
            if (!v[i]) begin
                zeros++;
            end
        end
        return v[9:7] == zeros[2:0];
    endfunction

    // Picks the value to emit for an RX symbol, or shifts a DX symbol into
    // the delay line and returns zero.
    function dsc_pkg::t_code pick_value(dsc_pkg::t_code code);
        dsc_pkg::t_code d;
        dsc_pkg::t_code chosen;
        d = dx_line[0];
        if (code[6:0] == phasing_symbol) begin
            rx_phase = 1'b0;
        end
        if (rx_phase) begin
            if (d[6:0] == phasing_symbol || d == code || code_ok(code)) begin
                chosen = code;
            end else if (code_ok(d)) begin
                chosen = d;
            end else if (code_ok(d | code)) begin
                chosen = d | code;
            end else if (code_ok(d & code)) begin
                chosen = d & code;
            end else begin
                chosen = dsc_pkg::EMPTY_VALUE;
            end
        end else begin
            dx_line[0] = dx_line[1];
            dx_line[1] = dx_line[2];
            dx_line[2] = code;
            chosen = '0;
        end
        rx_phase = ~rx_phase;
        return chosen;
    endfunction

    function void note_sample(logic signed [15:0] s);
        logic           b;
        logic           ok;
        dsc_pkg::t_code code;
        dsc_pkg::t_code chosen;
        word_t          w;
        b = ((s > 0) == invert);
        window = {b, window[9:1]};
        if (bits_needed > 4'd1) begin
            bits_needed--;
            return;
        end
        // Bits 7 and 9 travel swapped on the line.
        code = {window[7], window[8], window[9], window[6:0]};
        ok = code_ok(code);
        if (!ok && err_count > error_limit) begin
            bits_needed = 4'd1;
            slides++;
            return;
        end
        if (ok) begin
            err_count = '0;
        end else if (err_count != dsc_pkg::ERROR_COUNT_MAX) begin
            err_count++;
        end
        bits_needed = dsc_pkg::BITS_PER_SYMBOL;
        chosen = pick_value(code);
        if (chosen == '0) begin
            return;
        end
        if (code_ok(chosen)) begin
            w.symbol = chosen[6:0];
            w.empty  = 1'b0;
        end else begin
            w.symbol = '0;
            w.empty  = 1'b1;
        end
        expected_words.push_back(w);
    endfunction

    function void check_word(logic [6:0] symbol, logic empty);
        word_t w;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word symbol=%0d empty=%0b", $time, symbol, empty);
            errors++;
            return;
        end
        w = expected_words.pop_front();
        words_checked++;
        if (w.empty) begin
            empties++;
        end
        if (symbol !== w.symbol) begin
            $display("%0t: symbol mismatch, expected %0d, actual %0d", $time, w.symbol, symbol);
            errors++;
        end
        if (empty !== w.empty) begin
            $display("%0t: empty flag mismatch, expected %0b, actual %0b",
                     $time, w.empty, empty);
            errors++;
        end
    endfunction

endclass

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_SAMPLES  = 375;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_EVERY3,
        STALL_HEAVY
    } stall_mode_e;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [3:0]         paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid  = 1'b0;
    logic signed [15:0] i_sample    = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [6:0]         o_symbol;
    logic               o_empty_res;
    logic               i_out_stall = 1'b0;

    dsc_decode_scoreboard sb;

    logic           rst_done     = 1'b0;
    logic           hold_request = 1'b0;
    int             hold_left    = 0;
    int             idle_cycles  = 0;
    int             burst_left   = 0;
    int             samples_sent = 0;
    int             settings_used = 1;
    logic           cur_invert   = 1'b0;
    logic           tx_rx_slot   = 1'b0;
    dsc_pkg::t_code dx_hist [$];
    stall_mode_e    stall_mode   = STALL_NONE;
    int             mode_left    = 0;
    int             stall_tick   = 0;

    dsc_symbol_sync_and_fec_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_sample    (i_sample),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_symbol    (o_symbol),
        .o_empty_res (o_empty_res),
        .i_out_stall (i_out_stall)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------------
    function automatic logic [3:0] reg_addr(logic [1:0] index);
        return {index, 2'b00};
    endfunction

    task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= reg_addr(index);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] index, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= reg_addr(index);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got !== want) begin
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, index, want, got);
            sb.errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sample stream
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [15:0] s);
        int gap;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_sample(s);
        samples_sent++;
    endtask

    // A 1 is sent as a positive sample when invert is set, else as a
    // non-positive one.
    task automatic send_bit(input logic b);
        int mag;
        if (b ~^ cur_invert) begin
            mag = $urandom_range(1, 32767);
            send_sample(16'(mag));
        end else begin
            mag = $urandom_range(0, 32768);
            send_sample(16'(-mag));
        end
    endtask

    task automatic send_code(input dsc_pkg::t_code c);
        dsc_pkg::t_code w;
        w = {c[7], c[8], c[9], c[6:0]};
        for (int i = 0; i < 10; i++) begin
            send_bit(w[i]);
        end
    endtask

    function automatic dsc_pkg::t_code make_code(logic [6:0] info);
        logic [2:0] zeros;
        zeros = '0;
        for (int i = 0; i < 7; i++) begin
            zeros = zeros + {2'b00, ~info[i]};
        end
        return {zeros, info};
    endfunction

    function automatic dsc_pkg::t_code random_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return make_code(sb.phasing_symbol);
        end else if (r == 1) begin
            return '0;
        end
        return make_code(7'($urandom_range(0, 127)));
    endfunction

    // Mostly a DX/RX character stream where each RX repeats the DX sent three
    // DX slots earlier, with bit errors, noise bursts and bit slips mixed in.
    task automatic run_traffic(input int n);
        int             start;
        int             pick;
        dsc_pkg::t_code c;
        start = samples_sent;
        while (samples_sent - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                if (tx_rx_slot && dx_hist.size() == 3) begin
                    c = dx_hist[0];
                end else begin
                    c = random_char();
                end
                if (!tx_rx_slot) begin
                    dx_hist.push_back(c);
                    if (dx_hist.size() > 3) begin
                        void'(dx_hist.pop_front());
                    end
                end
                tx_rx_slot = ~tx_rx_slot;
                if ($urandom_range(0, 4) == 0) begin
                    c[$urandom_range(0, 9)] ^= 1'b1;
                    if ($urandom_range(0, 1) == 1) begin
                        c[$urandom_range(0, 9)] ^= 1'b1;
                    end
                end
                send_code(c);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 15)) send_bit(1'($urandom_range(0, 1)));
            end else if (pick < 95) begin
                send_bit(1'($urandom_range(0, 1)));
            end else begin
                send_code(10'($urandom_range(0, 1023)));
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        // A DX symbol still in flight produces no word, so give it time.
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic inv, input logic [7:0] limit,
                                 input logic [6:0] phasing);
        wait_drained();
        apb_write(dsc_pkg::REG_INVERT, {31'd0, inv});
        apb_write(dsc_pkg::REG_ERROR_LIMIT, {24'd0, limit});
        apb_write(dsc_pkg::REG_PHASING, {25'd0, phasing});
        check_reg(dsc_pkg::REG_INVERT, {31'd0, inv});
        check_reg(dsc_pkg::REG_ERROR_LIMIT, {24'd0, limit});
        check_reg(dsc_pkg::REG_PHASING, {25'd0, phasing});
        sb.invert         = inv;
        sb.error_limit    = limit;
        sb.phasing_symbol = phasing;
        cur_invert        = inv;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Word sink with its own stall pattern and one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic stall_next;
        if (rst_done && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_word(o_symbol, o_empty_res);
        end
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (mode_left == 0) begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        stall_tick++;
        if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:   stall_next = 1'b0;
                STALL_RANDOM: stall_next = ($urandom_range(0, 9) < 4);
                STALL_EVERY3: stall_next = (stall_tick % 3 == 0);
                default:      stall_next = ($urandom_range(0, 9) < 8);
            endcase
        end
        i_out_stall <= stall_next;
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles without any handshake
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        check_reg(dsc_pkg::REG_INVERT, 32'd0);
        check_reg(dsc_pkg::REG_ERROR_LIMIT, {24'd0, dsc_pkg::ERROR_LIMIT_RESET});
        check_reg(dsc_pkg::REG_PHASING, {25'd0, dsc_pkg::PHASING_RESET});

        // Sample extremes, zero and a sign flip, then a phasing symbol and a
        // plain character.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_code(make_code(sb.phasing_symbol));
        send_code(make_code(7'h55));

        // The sink holds off while samples keep coming, so the queue fills.
        hold_request = 1'b1;
        run_traffic(PHASE_SAMPLES);

        apply_setting(1'b1, 8'd0, 7'd0);
        run_traffic(PHASE_SAMPLES);
        apply_setting(1'b0, 8'd255, 7'd127);
        run_traffic(PHASE_SAMPLES);
        apply_setting(1'b1, 8'($urandom_range(1, 254)), 7'($urandom_range(0, 127)));
        run_traffic(PHASE_SAMPLES);
        apply_setting(1'b0, dsc_pkg::ERROR_LIMIT_RESET, dsc_pkg::PHASING_RESET);
        run_traffic(PHASE_SAMPLES);

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d samples over %0d register settings.",
                 samples_sent, settings_used);
        $display("Checked %0d words (%0d empty) with %0d window slides.",
                 sb.words_checked, sb.empties, sb.slides);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
